/* rtl/core/krte_pkg.sv */
// Package for the keyed route table engine.
// Holds command and status codes, the beat structs and the stored entry type.
// No dependencies.
package krte_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_GC     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam int ENTRY_W = 64 + 64 + 32 + 16 + 64 + 64;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] node_id_hi;
        logic [63:0] node_id_lo;
        logic [31:0] latency_value;
        logic [15:0] load_value;
        logic [63:0] entry_ttl;
        logic [63:0] entry_stamp;
        logic [63:0] now_time;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] expired_count;
        logic [6:0] entry_count;
    } t_out_beat;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [31:0] latency;
        logic [15:0] load;
        logic [63:0] ttl;
        logic [63:0] stamp;
    } t_entry;

endpackage

/* rtl/core/krte_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module krte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/krte_match.sv */
// Entry evaluation unit: key compare and expiry test on one stored entry.
// Depends on krte_pkg.
module krte_match (
    input  krte_pkg::t_entry i_entry,
    input  logic [63:0]      i_key_hi,
    input  logic [63:0]      i_key_lo,
    input  logic [63:0]      i_now,
    output logic             o_hit,
    output logic             o_keep
);
    logic [63:0] age;

    assign age    = i_now - i_entry.stamp;
    assign o_hit  = (i_entry.key_hi == i_key_hi) && (i_entry.key_lo == i_key_lo);
    assign o_keep = (i_entry.ttl == 64'd0) || (age <= i_entry.ttl);
endmodule

/* rtl/core/keyed_route_table_engine.sv */
// Top level of the keyed route table engine: sequencer, entry RAM, output register.
// Depends on krte_pkg, krte_ram and krte_match.
//
//  channel | direction | payload            | handshake
//  --------+-----------+--------------------+--------------------------
//  in      | input     | krte_pkg::t_in_beat  | i_in_valid / o_in_stall
//  out     | output    | krte_pkg::t_out_beat | o_out_valid / i_out_stall
//
// With N the entry count, the single RAM read port is stepped through the table one
// entry at a time (address, then registered data into the shared compare unit).
// Garbage collect walks all N entries; the search commands stop at the first match.
// Reset clears the entry count and the sequencer; the RAM contents stay undefined.
// The input stalls while a command runs and while a result waits to be taken.
// A result held by i_out_stall does not change.
module keyed_route_table_engine #(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  krte_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output krte_pkg::t_out_beat  o_out_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RADDR = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_MOVE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;   // read pointer
    logic [CW-1:0]      r_wr, n_wr;     // compaction write pointer
    logic [CW-1:0]      r_hole, n_hole;
    krte_pkg::t_in_beat r_cmd;
    logic               r_out_valid, n_out_valid;
    krte_pkg::t_out_beat r_out, n_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    krte_pkg::t_entry   ram_wdata, ram_rdata;
    logic               hit, keep;
    logic               accept;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;

    krte_ram #(.WIDTH(krte_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    krte_match u_match (
        .i_entry  (ram_rdata),
        .i_key_hi (r_cmd.node_id_hi),
        .i_key_lo (r_cmd.node_id_lo),
        .i_now    (r_cmd.now_time),
        .o_hit    (hit),
        .o_keep   (keep)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_wr   <= n_wr;
        r_hole <= n_hole;
        r_out  <= n_out;
        if (accept) begin
            r_cmd <= i_in_data;
        end
    end

    always_comb begin
        krte_pkg::t_entry fresh;
        fresh.key_hi  = r_cmd.node_id_hi;
        fresh.key_lo  = r_cmd.node_id_lo;
        fresh.latency = r_cmd.latency_value;
        fresh.load    = r_cmd.load_value;
        fresh.ttl     = r_cmd.entry_ttl;
        fresh.stamp   = r_cmd.entry_stamp;

        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_hole      = r_hole;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_wr[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_wr    = '0;
                    n_state = S_RADDR;
                end
            end
            S_RADDR: begin
                // Address presented this cycle; data is valid next cycle.
                if (r_idx >= r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_RADDR;
                if (r_cmd.cmd == krte_pkg::CMD_GC) begin
                    if (keep) begin
                        ram_we    = (r_wr != r_idx);
                        ram_waddr = r_wr[AW-1:0];
                        n_wr      = r_wr + 1'b1;
                    end
                end else if (hit) begin
                    n_hole = r_idx;
                    case (r_cmd.cmd)
                        krte_pkg::CMD_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx[AW-1:0];
                            ram_wdata = fresh;
                            n_out     = '{krte_pkg::ST_OK, 7'd0, 7'(r_count)};
                            n_state   = S_DONE;
                            n_idx     = r_count;
                        end
                        krte_pkg::CMD_UPDATE: begin
                            ram_we            = 1'b1;
                            ram_waddr         = r_idx[AW-1:0];
                            ram_wdata         = ram_rdata;
                            ram_wdata.latency = r_cmd.latency_value;
                            ram_wdata.load    = r_cmd.load_value;
                            n_state           = S_DONE;
                            n_idx             = r_count;
                        end
                        default: begin
                            // Remove: fetch the last entry to fill the hole.
                            n_idx   = r_count - 1'b1;
                            n_state = S_LAST;
                        end
                    endcase
                end
            end
            S_LAST: begin
                ram_raddr = r_idx[AW-1:0];
                n_state   = S_MOVE;
            end
            S_MOVE: begin
                ram_we    = (r_hole != r_idx);
                ram_waddr = r_hole[AW-1:0];
                n_count   = r_count - 1'b1;
                n_out     = '{krte_pkg::ST_OK, 7'd0, 7'(r_count - 1'b1)};
                n_out_valid = 1'b1;
                n_state   = S_IDLE;
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
                // r_idx equals r_count when the scan found no match.
                case (r_cmd.cmd)
                    krte_pkg::CMD_INSERT: begin
                        if (r_idx != r_count || r_hole != r_count) begin
                            n_out = '{krte_pkg::ST_OK, 7'd0, 7'(r_count)};
                        end else if (r_count >= CW'(DEPTH)) begin
                            n_out = '{krte_pkg::ST_FULL, 7'd0, 7'(r_count)};
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[AW-1:0];
                            ram_wdata = fresh;
                            n_count   = r_count + 1'b1;
                            n_out     = '{krte_pkg::ST_OK, 7'd0, 7'(r_count + 1'b1)};
                        end
                    end
                    krte_pkg::CMD_UPDATE: begin
                        if (r_hole != r_count) begin
                            n_out = '{krte_pkg::ST_OK, 7'd0, 7'(r_count)};
                        end else begin
                            n_out = '{krte_pkg::ST_NOT_FOUND, 7'd0, 7'(r_count)};
                        end
                    end
                    krte_pkg::CMD_GC: begin
                        n_count = r_wr;
                        n_out   = '{krte_pkg::ST_OK, 7'(r_count - r_wr), 7'(r_wr)};
                    end
                    default: begin
                        n_out = '{krte_pkg::ST_NOT_FOUND, 7'd0, 7'(r_count)};
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The hole marker doubles as the match flag; it is reset at the start.
        if (r_state == S_IDLE) begin
            n_hole = r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result never appears while a command is still in flight.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_state == S_IDLE))
        else $error("result raised outside idle");

    // The entry count never exceeds the table depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count overflow");

    // A stalled result holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out))
        else $error("stalled result changed");

    // No input is taken while a result waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input taken with pending result");
endmodule

/* dv/keyed_route_table_engine_tb.sv */
// Self-checking bench for the keyed route table engine.
// Runs a directed table, a fill to capacity and a random command stream against an in-bench route table.
// Depends on krte_pkg and the keyed_route_table_engine RTL.
module keyed_route_table_engine_tb;

    localparam int TBL_DEPTH = 64;
    localparam int NUM_RANDOM = 1100;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    krte_pkg::t_in_beat  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    krte_pkg::t_out_beat o_out_data;

    keyed_route_table_engine #(.DEPTH(TBL_DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    // Shadow copy of the route table, kept in the same order as the block keeps it.
    krte_pkg::t_entry    shadow_tbl [TBL_DEPTH];
    int                  shadow_cnt;
    krte_pkg::t_out_beat pending_results[$];
    int                  mismatches;
    bit                  no_idle;

    // Small key pool so that hits, duplicates and misses all occur often.
    logic [63:0] key_pool_hi [8];
    logic [63:0] key_pool_lo [8];

    typedef struct {
        krte_pkg::t_in_beat  beat;
        bit                  has_golden;
        krte_pkg::t_out_beat golden;
    } t_dir_row;

    t_dir_row dir_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #80000000;
        $display("keyed_route_table_engine_tb failed");
        $finish;
    end

    function automatic int find_key(logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < shadow_cnt; i++) begin
            if (shadow_tbl[i].key_hi == hi && shadow_tbl[i].key_lo == lo) return i;
        end
        return -1;
    endfunction

    // Applies one command to the shadow table and returns the result it must give.
    function automatic krte_pkg::t_out_beat apply_route_cmd(krte_pkg::t_in_beat b);
        krte_pkg::t_out_beat r;
        int idx;
        int w;
        logic [63:0] age;
        r = '0;
        r.status = krte_pkg::ST_OK;
        idx = find_key(b.node_id_hi, b.node_id_lo);
        case (b.cmd)
            krte_pkg::CMD_INSERT: begin
                if (idx < 0 && shadow_cnt >= TBL_DEPTH) begin
                    r.status = krte_pkg::ST_FULL;
                end else begin
                    if (idx < 0) begin
                        idx = shadow_cnt;
                        shadow_cnt++;
                    end
                    shadow_tbl[idx] = '{b.node_id_hi, b.node_id_lo, b.latency_value,
                                        b.load_value, b.entry_ttl, b.entry_stamp};
                end
            end
            krte_pkg::CMD_REMOVE: begin
                if (idx < 0) begin
                    r.status = krte_pkg::ST_NOT_FOUND;
                end else begin
                    shadow_tbl[idx] = shadow_tbl[shadow_cnt-1];
                    shadow_cnt--;
                end
            end
            krte_pkg::CMD_UPDATE: begin
                if (idx < 0) begin
                    r.status = krte_pkg::ST_NOT_FOUND;
                end else begin
                    shadow_tbl[idx].latency = b.latency_value;
                    shadow_tbl[idx].load = b.load_value;
                end
            end
            default: begin
                w = 0;
                for (int i = 0; i < shadow_cnt; i++) begin
                    age = b.now_time - shadow_tbl[i].stamp;
                    if (shadow_tbl[i].ttl == 64'd0 || age <= shadow_tbl[i].ttl) begin
                        shadow_tbl[w] = shadow_tbl[i];
                        w++;
                    end
                end
                r.expired_count = 7'(shadow_cnt - w);
                shadow_cnt = w;
            end
        endcase
        r.entry_count = 7'(shadow_cnt);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic krte_pkg::t_in_beat make_beat(logic [1:0] c, logic [63:0] hi,
                                                     logic [63:0] lo, logic [63:0] ttl,
                                                     logic [63:0] stamp,
                                                     logic [63:0] now_t);
        krte_pkg::t_in_beat b;
        b.cmd = c;
        b.node_id_hi = hi;
        b.node_id_lo = lo;
        b.latency_value = $urandom;
        b.load_value = 16'($urandom);
        b.entry_ttl = ttl;
        b.entry_stamp = stamp;
        b.now_time = now_t;
        return b;
    endfunction

    function automatic krte_pkg::t_in_beat random_beat();
        krte_pkg::t_in_beat b;
        int k;
        int r;
        logic [63:0] base;
        k = $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        b = make_beat(krte_pkg::CMD_INSERT, key_pool_hi[k], key_pool_lo[k],
                      64'd0, 64'd0, 64'd0);
        if ($urandom_range(0, 9) == 0) begin
            b.node_id_hi = rand64();
            b.node_id_lo = rand64();
        end
        if ($urandom_range(0, 7) == 0) b.latency_value = '1;
        if ($urandom_range(0, 7) == 0) b.load_value = '1;
        // Times stay near a wrapping base so that expiry hits both sides of the ttl.
        base = $urandom_range(0, 3) == 0 ? 64'hFFFF_FFFF_FFFF_FF00 : 64'd1000;
        b.entry_stamp = base + 64'($urandom_range(0, 200));
        b.entry_ttl = $urandom_range(0, 4) == 0 ? 64'd0 : 64'($urandom_range(1, 300));
        if ($urandom_range(0, 15) == 0) b.entry_ttl = rand64();
        if ($urandom_range(0, 15) == 0) b.entry_stamp = rand64();
        b.now_time = base + 64'($urandom_range(0, 500));
        if ($urandom_range(0, 15) == 0) b.now_time = rand64();
        if (r < 45) b.cmd = krte_pkg::CMD_INSERT;
        else if (r < 65) b.cmd = krte_pkg::CMD_REMOVE;
        else if (r < 85) b.cmd = krte_pkg::CMD_UPDATE;
        else b.cmd = krte_pkg::CMD_GC;
        return b;
    endfunction

    // Valid stays high from one beat to the next unless an idle burst is drawn.
    task automatic send_beat(krte_pkg::t_in_beat b);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_route_cmd(b));
        @(negedge i_clk);
    endtask

    // Receiver side stall pattern: random bursts, none in the final stretch.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // Result checker: each accepted result beat is compared with the oldest prediction.
    always @(posedge i_clk) begin
        krte_pkg::t_out_beat exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", o_out_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_out_data.status !== exp_r.status ||
                    o_out_data.expired_count !== exp_r.expired_count ||
                    o_out_data.entry_count !== exp_r.entry_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", exp_r, o_out_data);
                end
            end
        end
    end

    initial begin
        krte_pkg::t_in_beat b;
        krte_pkg::t_out_beat g;
        int wait_cycles;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        mismatches = 0;
        shadow_cnt = 0;
        no_idle = 1'b0;
        for (int k = 0; k < 8; k++) begin
            key_pool_hi[k] = rand64();
            key_pool_lo[k] = rand64();
        end
        key_pool_hi[0] = '0;
        key_pool_lo[0] = '0;
        key_pool_hi[1] = '1;
        key_pool_lo[1] = '1;
        // Same upper half as key 1, so only the lower half tells them apart.
        key_pool_hi[2] = '1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table; golden values only where they are obvious.
        g = '0;
        g.status = krte_pkg::ST_NOT_FOUND;
        dir_rows.push_back('{make_beat(krte_pkg::CMD_REMOVE, '1, '1, 0, 0, 0), 1, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_UPDATE, 0, 0, 0, 0, 0), 1, g});
        g.status = krte_pkg::ST_OK;
        dir_rows.push_back('{make_beat(krte_pkg::CMD_GC, 0, 0, 0, 0, '1), 1, g});
        g.entry_count = 7'd1;
        b = make_beat(krte_pkg::CMD_INSERT, 0, 0, 0, 0, 0);
        b.latency_value = '1;
        b.load_value = '1;
        dir_rows.push_back('{b, 1, g});
        g.entry_count = 7'd2;
        dir_rows.push_back('{make_beat(krte_pkg::CMD_INSERT, '1, '1, 64'd10, 64'd100, 0),
                             1, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_INSERT, '1, '1, 64'd20, 64'd100, 0),
                             1, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_UPDATE, '1, '1, 0, 0, 0), 1, g});
        // Wrapping stamp near the top of the time range with a short ttl.
        dir_rows.push_back('{make_beat(krte_pkg::CMD_INSERT, '1, 64'd5, 64'd50,
                                       64'hFFFF_FFFF_FFFF_FFF0, 0), 0, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_INSERT, 64'd7, 64'd9, '1, 64'd0, 0),
                             0, g});
        // Age exactly equal to ttl survives.
        dir_rows.push_back('{make_beat(krte_pkg::CMD_GC, 0, 0, 0, 0, 64'd120), 0, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_GC, 0, 0, 0, 0, 64'd34), 0, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_GC, 0, 0, 0, 0, 64'd121), 0, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_REMOVE, 0, 0, 0, 0, 0), 0, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_REMOVE, 64'd7, 64'd9, 0, 0, 0), 0, g});
        dir_rows.push_back('{make_beat(krte_pkg::CMD_GC, 0, 0, 0, 0, 0), 0, g});
        foreach (dir_rows[r]) begin
            send_beat(dir_rows[r].beat);
            if (dir_rows[r].has_golden) pending_results[$] = dir_rows[r].golden;
        end

        // Fill the table to capacity, then overwrite in a full table and overflow it.
        while (shadow_cnt < TBL_DEPTH)
            send_beat(make_beat(krte_pkg::CMD_INSERT, rand64(), rand64(), 0, 0, 0));
        send_beat(make_beat(krte_pkg::CMD_INSERT, shadow_tbl[TBL_DEPTH-1].key_hi,
                            shadow_tbl[TBL_DEPTH-1].key_lo, 64'd1, 64'd0, 0));
        g = '0;
        g.status = krte_pkg::ST_FULL;
        g.entry_count = 7'(TBL_DEPTH);
        send_beat(make_beat(krte_pkg::CMD_INSERT, rand64(), rand64(), 0, 0, 0));
        pending_results[$] = g;
        // Run gc at time 5 and at the top of the time range; only entries with a zero ttl stay.
        send_beat(make_beat(krte_pkg::CMD_GC, 0, 0, 0, 0, 64'd5));
        send_beat(make_beat(krte_pkg::CMD_GC, 0, 0, 0, 0, '1));

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - 150) no_idle = 1'b1;
            send_beat(random_beat());
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2 * TBL_DEPTH + 8) @(posedge i_clk);
        if (pending_results.size() == 0 && mismatches == 0) begin
            $display("keyed_route_table_engine_tb passed");
        end else begin
            $display("keyed_route_table_engine_tb failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/krte_pkg.sv
rtl/core/krte_ram.sv
rtl/core/krte_match.sv
rtl/core/keyed_route_table_engine.sv
dv/keyed_route_table_engine_tb.sv
